[rtl/longest_subarray_target_sum_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef LONGEST_SUBARRAY_TARGET_SUM_MACROS_SVH
`define LONGEST_SUBARRAY_TARGET_SUM_MACROS_SVH

// Checked at every rising clock edge, ignored while reset is asserted.
`define LSTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define LSTS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lsts_pkg.sv]
package lsts_pkg;

    localparam int DEFAULT_MAX_LEN = 64;
    localparam int ELEM_W          = 16;
    localparam int TARGET_W        = 32;
    localparam int BEST_W          = 7;
    localparam int S_TDATA_W       = 16;
    localparam int S_TUSER_W       = 1;
    localparam int M_TDATA_W       = 16;
    localparam int M_PAD_W         = M_TDATA_W - BEST_W - 2;

endpackage

[rtl/longest_subarray_target_sum.sv]
// Longest contiguous run whose sum equals target_sum, over arrays that stream
// in one element per item (tuser marks the first element, tlast the last).
// Every input item yields one result item with the longest run found so far
// in the current array, a found flag and a sticky overflow flag; elements
// past MAX_LEN are dropped. The block takes one item per cycle while the
// chain is not stalled. Each item walks a chain of MAX_LEN cells, one cell
// per cycle while not stalled, where cell j holds the prefix sum after
// element j; its result is registered at the output. When a result waits
// at the output and the chain holds an item in its last stage, the whole
// chain stalls. Write target_sum only while no items are in flight.
module longest_subarray_target_sum #(
    parameter int MAX_LEN = lsts_pkg::DEFAULT_MAX_LEN
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [lsts_pkg::TARGET_W-1:0]        cfg_wdata,   // target_sum
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lsts_pkg::S_TDATA_W-1:0]       s_tdata,     // elem_value
    input  logic [lsts_pkg::S_TUSER_W-1:0]       s_tuser,     // is_first
    input  logic                                 s_tlast,     // is_last
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lsts_pkg::M_TDATA_W-1:0]       m_tdata,     // best_length, found, overflow
    output logic                                 m_tlast      // final_res
);

    localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PW     = lsts_pkg::ELEM_W + CNT_W;
    localparam int CW     = ((PW > lsts_pkg::TARGET_W) ? PW : lsts_pkg::TARGET_W) + 1;

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic                 drop;
        logic                 ovf;
        logic                 self_hit;
        logic                 hit;
        logic [IDX_W-1:0]     pos;
        logic [IDX_W-1:0]     hit_idx;
        logic signed [CW-1:0] key;
    } query_t;

    logic signed [lsts_pkg::TARGET_W-1:0] target_reg;
    logic                                 adv, accept, wr_en;
    logic [IDX_W-1:0]                     wr_idx;
    logic signed [PW-1:0]                 wr_data;
    query_t                               q_chain [MAX_LEN+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_we) begin
            target_reg <= cfg_wdata;
        end
    end

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    lsts_front #(
        .MAX_LEN (MAX_LEN),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W),
        .PW      (PW),
        .CW      (CW),
        .query_t (query_t)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .accept     (accept),
        .elem_value (s_tdata),
        .is_first   (s_tuser[0]),
        .is_last    (s_tlast),
        .target_sum (target_reg),
        .q_out      (q_chain[0]),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data)
    );

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        lsts_cell #(
            .CELL_IDX (i),
            .IDX_W    (IDX_W),
            .PW       (PW),
            .CW       (CW),
            .query_t  (query_t)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .wr_en   (wr_en),
            .wr_idx  (wr_idx),
            .wr_data (wr_data),
            .q_in    (q_chain[i]),
            .q_out   (q_chain[i+1])
        );
    end

    lsts_tail #(
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W),
        .query_t (query_t)
    ) u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_in     (q_chain[MAX_LEN]),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/lsts_front.sv]
module lsts_front #(
    parameter int MAX_LEN = lsts_pkg::DEFAULT_MAX_LEN,
    parameter int IDX_W   = 6,
    parameter int CNT_W   = 7,
    parameter int PW      = 23,
    parameter int CW      = 33,
    parameter type query_t = logic
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                accept,
    input  logic signed [lsts_pkg::ELEM_W-1:0]   elem_value,
    input  logic                                is_first,
    input  logic                                is_last,
    input  logic signed [lsts_pkg::TARGET_W-1:0] target_sum,
    output query_t                              q_out,
    output logic                                wr_en,
    output logic [IDX_W-1:0]                    wr_idx,
    output logic signed [PW-1:0]                wr_data
);

    logic [CNT_W-1:0]     cnt_reg, cnt_next, base_cnt;
    logic signed [PW-1:0] prefix_reg, prefix_next, base_pre, sum;
    logic                 ovf_reg, ovf_next, base_ovf, drop;
    logic signed [CW-1:0] key;
    query_t               q_reg, q_next;

    always_comb begin
        base_cnt = is_first ? '0 : cnt_reg;
        base_pre = is_first ? '0 : prefix_reg;
        base_ovf = is_first ? 1'b0 : ovf_reg;
        drop     = (base_cnt >= CNT_W'(MAX_LEN));
        sum      = base_pre + PW'(elem_value);
        key      = CW'(sum) - CW'(target_sum);

        cnt_next    = cnt_reg;
        prefix_next = prefix_reg;
        ovf_next    = ovf_reg;
        if (accept) begin
            cnt_next    = drop ? base_cnt : base_cnt + CNT_W'(1);
            prefix_next = drop ? base_pre : sum;
            ovf_next    = base_ovf | drop;
        end

        q_next          = q_reg;
        q_next.valid    = accept;
        q_next.first    = is_first;
        q_next.last     = is_last;
        q_next.drop     = drop;
        q_next.ovf      = base_ovf | drop;
        q_next.self_hit = !drop && (key == '0);
        q_next.hit      = 1'b0;
        q_next.pos      = base_cnt[IDX_W-1:0];
        q_next.hit_idx  = '0;
        q_next.key      = key;

        wr_en   = accept && !drop;
        wr_idx  = base_cnt[IDX_W-1:0];
        wr_data = sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            prefix_reg  <= '0;
            ovf_reg     <= 1'b0;
            q_reg.valid <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            prefix_reg <= prefix_next;
            ovf_reg    <= ovf_next;
            if (adv) begin
                q_reg <= q_next;
            end
        end
    end

    assign q_out = q_reg;

endmodule

[rtl/lsts_cell.sv]
module lsts_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 6,
    parameter int PW       = 23,
    parameter int CW       = 33,
    parameter type query_t = logic
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic signed [PW-1:0] wr_data,
    input  query_t               q_in,
    output query_t               q_out
);

    logic signed [PW-1:0] stored_reg;
    query_t               q_reg, q_next;
    logic                 match;

    always_comb begin
        match = q_in.valid && !q_in.drop && !q_in.hit
                && (IDX_W'(CELL_IDX) < q_in.pos)
                && (CW'(stored_reg) == q_in.key);
        q_next = q_in;
        if (match) begin
            q_next.hit     = 1'b1;
            q_next.hit_idx = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
            stored_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (adv) begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule

[rtl/lsts_tail.sv]
module lsts_tail #(
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7,
    parameter type query_t = logic
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  query_t                          q_in,
    output logic                            adv,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lsts_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    logic [CNT_W-1:0]               best_reg, best_next, base_best, cand;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [lsts_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                           m_tlast_reg, m_tlast_next;
    logic                           out_free;

    always_comb begin
        out_free = !m_tvalid_reg || m_tready;
        adv      = !q_in.valid || out_free;

        if (q_in.self_hit) begin
            cand = CNT_W'(q_in.pos) + CNT_W'(1);
        end else if (q_in.hit) begin
            cand = CNT_W'(q_in.pos - q_in.hit_idx);
        end else begin
            cand = '0;
        end
        base_best = q_in.first ? '0 : best_reg;

        best_next     = best_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_free) begin
            m_tvalid_next = q_in.valid;
            if (q_in.valid) begin
                best_next    = (cand > base_best) ? cand : base_best;
                m_tdata_next = {lsts_pkg::M_PAD_W'(0), q_in.ovf, (best_next != '0),
                                lsts_pkg::BEST_W'(best_next)};
                m_tlast_next = q_in.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            best_reg     <= best_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/lsts_checker.sv]
`include "longest_subarray_target_sum_macros.svh"

module lsts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lsts_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // A result that is not taken stays offered unchanged.
    `LSTS_ASSERT(a_result_hold, aclk, aresetn, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result item changed")

    // A nonzero length always comes with the found flag.
    `LSTS_ASSERT(a_found_flag, aclk, aresetn, (m_tvalid && (m_tdata[6:0] != 7'd0) |-> m_tdata[7]), "nonzero best length without found flag")

    // With the output empty the chain always moves, so the input is ready.
    `LSTS_ASSERT(a_ready_when_empty, aclk, aresetn, (!m_tvalid |-> s_tready), "input stalled while output is empty")

    // Reset leaves no result offered.
    `LSTS_ASSERT_ALWAYS(a_reset_clears, aclk, (!aresetn |=> !m_tvalid), "result offered after reset")

endmodule

bind longest_subarray_target_sum lsts_checker u_checker (.*);

[tb/tb_top.sv]
module tb_top;

    localparam int CAP         = lsts_pkg::DEFAULT_MAX_LEN;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG    = 4000;

    typedef struct {
        logic signed [lsts_pkg::ELEM_W-1:0] elem;
        logic                               first;
        logic                               last;
    } elem_item_t;

    typedef struct {
        logic [lsts_pkg::BEST_W-1:0] best_length;
        logic                        found;
        logic                        overflow;
        logic                        final_res;
    } run_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [lsts_pkg::TARGET_W-1:0]   cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lsts_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic [lsts_pkg::S_TUSER_W-1:0]  s_tuser = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lsts_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;

    elem_item_t  pending_items[$];
    run_result_t expected_runs[$];
    elem_item_t  cur_item;

    // Shadow copy of the block's array state.
    longint      target_val = 0;
    longint      run_prefix = 0;
    int          held_count = 0;
    int          best_run = 0;
    bit          dropped = 1'b0;
    longint      prefix_mem[CAP];
    bit          prefix_ok[CAP] = '{default: 1'b0};

    int          err_count = 0;
    int          idle_cycles = 0;
    int          src_wait = 0;
    int          sink_wait = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          hold_req = 0;
    int          hold_seen = 0;

    longest_subarray_target_sum uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic run_result_t next_best_run(input elem_item_t it);
        run_result_t r;
        longint      want;
        if (it.first) begin
            run_prefix = 0;
            held_count = 0;
            best_run = 0;
            dropped = 1'b0;
            prefix_ok = '{default: 1'b0};
        end
        if (held_count >= CAP) begin
            dropped = 1'b1;
        end else begin
            run_prefix += longint'(it.elem);
            if (run_prefix == target_val && held_count + 1 > best_run) begin
                best_run = held_count + 1;
            end
            want = run_prefix - target_val;
            for (int j = 0; j < held_count; j++) begin
                if (prefix_ok[j] && prefix_mem[j] == want) begin
                    if (held_count - j > best_run) begin
                        best_run = held_count - j;
                    end
                    break;
                end
            end
            prefix_mem[held_count] = run_prefix;
            prefix_ok[held_count] = 1'b1;
            held_count++;
        end
        r.best_length = best_run[lsts_pkg::BEST_W-1:0];
        r.found = (best_run != 0);
        r.overflow = dropped;
        r.final_res = it.last;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(99) < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 100);
    endfunction

    function automatic logic signed [lsts_pkg::ELEM_W-1:0] gen_elem(input int style);
        int r;
        r = $urandom_range(99);
        if (r < 6) begin
            return 16'sh7FFF;
        end
        if (r < 12) begin
            return 16'sh8000;
        end
        if (r < ((style != 0) ? 50 : 20)) begin
            return lsts_pkg::ELEM_W'($urandom);
        end
        return lsts_pkg::ELEM_W'($urandom_range(8)) - 16'd4;
    endfunction

    task automatic add_item(input logic signed [lsts_pkg::ELEM_W-1:0] e,
                            input bit f, input bit l);
        elem_item_t it;
        it.elem = e;
        it.first = f;
        it.last = l;
        pending_items.push_back(it);
    endtask

    // Most arrays are well formed; a few lack the first or last mark, and
    // stray marks occasionally land in the middle.
    task automatic add_array(input int len, input int style);
        bit with_first;
        bit with_last;
        with_first = ($urandom_range(99) >= 8);
        with_last = ($urandom_range(99) >= 8);
        for (int k = 0; k < len; k++) begin
            add_item(gen_elem(style),
                     ((k == 0) && with_first) || ($urandom_range(99) == 0),
                     ((k == len - 1) && with_last) || ($urandom_range(99) < 2));
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_runs.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic set_target(input logic signed [lsts_pkg::TARGET_W-1:0] v);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        target_val = longint'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_count++;
        end
    endtask

    // Driver: offers queued items, with random gaps after some of them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_runs.push_back(next_best_run(cur_item));
            end
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata <= cur_item.elem;
                    s_tuser <= cur_item.first;
                    s_tlast <= cur_item.last;
                    s_tvalid <= 1'b1;
                    if (src_idle_en && $urandom_range(99) < 20) begin
                        src_wait = pick_gap();
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item and applies random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_runs.size() == 0) begin
                    $error("result item with no expected item waiting");
                    err_count++;
                end else begin
                    run_result_t e;
                    e = expected_runs.pop_front();
                    check_field("best_length", e.best_length,
                                m_tdata[lsts_pkg::BEST_W-1:0]);
                    check_field("found", e.found, m_tdata[lsts_pkg::BEST_W]);
                    check_field("overflow", e.overflow, m_tdata[lsts_pkg::BEST_W+1]);
                    check_field("final_res", e.final_res, m_tlast);
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                sink_wait = HOLD_CYCLES;
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(99) < 20) begin
                sink_wait = pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_items.size() == 0 && !s_tvalid && expected_runs.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("longest_subarray_target_sum verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                                    n;
        int                                    len;
        int                                    r;
        int                                    style;
        logic signed [lsts_pkg::TARGET_W-1:0]  tgt;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Target 0 from reset: elements before any first mark append to the
        // empty array, and elements after a last mark keep appending.
        @(negedge aclk);
        add_item(5, 1'b0, 1'b0);
        add_item(-5, 1'b0, 1'b0);
        add_item(32767, 1'b1, 1'b0);
        add_item(-32768, 1'b0, 1'b0);
        add_item(1, 1'b0, 1'b1);
        add_item(0, 1'b0, 1'b0);
        add_item(7, 1'b1, 1'b1);

        // Zero elements make the earliest matching prefix give the longest run.
        set_target(4);
        @(negedge aclk);
        add_item(1, 1'b1, 1'b0);
        add_item(0, 1'b0, 1'b0);
        add_item(0, 1'b0, 1'b0);
        add_item(4, 1'b0, 1'b1);
        add_item(2, 1'b1, 1'b0);
        add_item(2, 1'b0, 1'b1);

        for (int p = 0; p < 12; p++) begin
            style = 0;
            case (p)
                0: tgt = 0;
                1: tgt = 3;
                2: tgt = -5;
                3: begin
                    tgt = 32767;
                    style = 1;
                end
                4: begin
                    tgt = -32768;
                    style = 1;
                end
                5: tgt = 32'sh7FFF_FFFF;
                6: tgt = 32'sh8000_0000;
                7: begin
                    tgt = 65534;
                    style = 1;
                end
                8: tgt = -2;
                9: tgt = $urandom_range(20) - 10;
                10: tgt = 1;
                default: tgt = 0;
            endcase
            set_target(tgt);
            src_idle_en = (p % 3 != 1);
            sink_idle_en = (p % 4 != 2);
            @(negedge aclk);
            n = 0;
            while (n < 125) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    len = $urandom_range(CAP + 1, CAP + 8);
                end else if (r < 15) begin
                    len = $urandom_range(20, CAP);
                end else begin
                    len = $urandom_range(1, 12);
                end
                add_array(len, style);
                n += len;
            end
            if (p == 3) begin
                hold_req <= hold_req + 1;
            end
            wait_drained();
        end

        repeat (CAP + 10) @(posedge aclk);
        if (expected_runs.size() != 0) begin
            $error("%0d expected result items never arrived", expected_runs.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("longest_subarray_target_sum verification clean");
        end else begin
            $display("longest_subarray_target_sum verification failed");
        end
        $finish;
    end

endmodule
